// ===== sv/binary_morphology_3x3_top_defines.svh =====
// Assertion helpers for the 3x3 morphology block.
`ifndef BINARY_MORPHOLOGY_3X3_TOP_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define BM3_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent implies consequent in the following cycle.
`define BM3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BM3_ASSERT(name, prop, msg)
`define BM3_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== sv/bm3_pkg.sv =====
package bm3_pkg;

    localparam int CFG_W       = 11;
    localparam int OUT_COORD_W = 10;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - 2 * OUT_COORD_W;
    localparam int NUM_RES     = 4;
    localparam int CNT_W       = $clog2(NUM_RES + 1);

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_WIDTH  = 2'd0;
    localparam cfg_index_t REG_HEIGHT = 2'd1;
    localparam cfg_index_t REG_OP     = 2'd2;

    localparam logic OP_DILATE = 1'b0;
    localparam logic OP_ERODE  = 1'b1;

    typedef logic [1:0] row_slot_t;
    localparam row_slot_t ROW_SLOT_0 = 2'd0;
    localparam row_slot_t ROW_SLOT_1 = 2'd1;
    localparam row_slot_t ROW_SLOT_2 = 2'd2;

    typedef struct packed {
        logic                   pixel;
        logic [OUT_COORD_W-1:0] row;
        logic [OUT_COORD_W-1:0] col;
        logic                   frame_end;
    } result_t;

    typedef struct packed {
        result_t [NUM_RES-1:0] res;
        logic [CNT_W-1:0]      count;
    } load_t;

    typedef struct packed {
        logic shift;
        logic op;
        logic use_top;
    } cell_ctrl_t;

    function automatic logic reduce2(input logic op, input logic a, input logic b);
        return (op == OP_ERODE) ? (a & b) : (a | b);
    endfunction

endpackage

// ===== sv/binary_morphology_3x3_top.sv =====
// Channel   | Dir | Signals                             | Contents (low bit up)
// ----------+-----+-------------------------------------+------------------------------
// s_axis    | in  | tvalid, tready, tdata[7:0]          | pixel_in
// m_axis    | out | tvalid, tready, tdata[23:0], tlast  | pixel_out, out_row, out_col; frame_end
// cfg       | in  | cfg_we, cfg_index, cfg_data[10:0]   | width, height, operation
//
// One pixel per cycle while the output takes results; a pixel with more results (row ends,
// last row) holds the input until the queue can load them, as the output port moves one
// result per transfer. Pixels pass stage 1 and stage 2, then the result queue.
// Reset sets default config and clears position, stage valids and queue count, not line store.
// Output stalls back up through a 4-entry result queue and the two pixel stages.
`include "binary_morphology_3x3_top_defines.svh"
module binary_morphology_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  bm3_pkg::cfg_index_t                cfg_index,
    input  logic [bm3_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bm3_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [0] pixel_in
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bm3_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [0] pixel_out,
                                                               // [10:1] out_row,
                                                               // [20:11] out_col
    output logic                               m_axis_tlast    // frame_end
);
    import bm3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WSZ = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int HSZ = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic          a_v;
        logic          b_v;
        logic          c_v;
        logic          d_v;
        logic          col_ge2;
        logic          row_ge2;
    } meta_t;

    // configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1024);
            height_reg <= CFG_W'(1024);
            op_reg     <= OP_DILATE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_OP:     op_reg     <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    logic [WSZ-1:0] width_ext;
    logic [HSZ-1:0] height_ext;
    logic [CW:0]    w_eff;
    logic [RW:0]    h_eff;
    logic [CW-1:0]  w_last;
    logic [RW-1:0]  h_last;

    always_comb
    begin
        width_ext  = WSZ'(width_reg);
        height_ext = HSZ'(height_reg);
        if (width_ext < WSZ'(2))
            w_eff = (CW + 1)'(2);
        else if (width_ext > WSZ'(MAX_WIDTH))
            w_eff = (CW + 1)'(MAX_WIDTH);
        else
            w_eff = (CW + 1)'(width_ext);
        if (height_ext < HSZ'(2))
            h_eff = (RW + 1)'(2);
        else if (height_ext > HSZ'(MAX_HEIGHT))
            h_eff = (RW + 1)'(MAX_HEIGHT);
        else
            h_eff = (RW + 1)'(height_ext);
        w_last = CW'(w_eff - (CW + 1)'(1));
        h_last = RW'(h_eff - (RW + 1)'(1));
    end

    // raster position
    logic [CW-1:0] col_reg, col_next, c_cur;
    logic [RW-1:0] row_reg, row_next, r_cur;
    row_slot_t     slot_reg, slot_next, slot_cur;
    logic          restart, at_last_col, at_last_row;
    logic          in_accept;
    meta_t         meta_in;

    assign in_accept = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        restart     = ({1'b0, col_reg} >= w_eff) || ({1'b0, row_reg} >= h_eff);
        c_cur       = restart ? '0 : col_reg;
        r_cur       = restart ? '0 : row_reg;
        slot_cur    = restart ? ROW_SLOT_0 : slot_reg;
        at_last_col = (c_cur == w_last);
        at_last_row = (r_cur == h_last);

        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (in_accept)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                if (at_last_row)
                begin
                    row_next  = '0;
                    slot_next = ROW_SLOT_0;
                end
                else
                begin
                    row_next  = r_cur + RW'(1);
                    slot_next = (slot_cur == ROW_SLOT_2) ? ROW_SLOT_0
                                                         : row_slot_t'(slot_cur + 2'd1);
                end
            end
            else
            begin
                col_next  = c_cur + CW'(1);
                row_next  = r_cur;
                slot_next = slot_cur;
            end
        end

        meta_in.row     = r_cur;
        meta_in.col     = c_cur;
        meta_in.a_v     = (r_cur != '0) && (c_cur != '0);
        meta_in.b_v     = (r_cur != '0) && at_last_col;
        meta_in.c_v     = at_last_row && (c_cur != '0);
        meta_in.d_v     = at_last_row && at_last_col;
        meta_in.col_ge2 = (c_cur > CW'(1));
        meta_in.row_ge2 = (r_cur > RW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= ROW_SLOT_0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // stage 1: line store read returns
    logic      p1_valid_reg, p2_valid_reg;
    logic      p1_px_reg;
    row_slot_t p1_slot_reg;
    meta_t     p1_meta_reg, p2_meta_reg;
    logic      p1_take, p2_ready, load_en, load_ready;

    assign p2_ready      = !p2_valid_reg || load_en;
    assign p1_take       = p1_valid_reg && p2_ready;
    assign s_axis_tready = !p1_valid_reg || p2_ready;
    assign load_en       = p2_valid_reg && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                p1_valid_reg <= 1'b1;
            else if (p1_take)
                p1_valid_reg <= 1'b0;
            if (p1_take)
                p2_valid_reg <= 1'b1;
            else if (load_en)
                p2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p1_px_reg   <= s_axis_tdata[0];
            p1_slot_reg <= slot_cur;
            p1_meta_reg <= meta_in;
        end
        if (p1_take)
        begin
            p2_meta_reg <= p1_meta_reg;
        end
    end

    logic [2:0] ram_rd_data, ram_wr_data, new_col;

    bm3_ram #(
        .WIDTH (3),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (p1_take),
        .wr_addr (p1_meta_reg.col),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (c_cur),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        unique case (p1_slot_reg)
            ROW_SLOT_0:
            begin
                ram_wr_data = {ram_rd_data[2:1], p1_px_reg};
                new_col     = {ram_rd_data[1], ram_rd_data[2], p1_px_reg};
            end
            ROW_SLOT_1:
            begin
                ram_wr_data = {ram_rd_data[2], p1_px_reg, ram_rd_data[0]};
                new_col     = {ram_rd_data[2], ram_rd_data[0], p1_px_reg};
            end
            ROW_SLOT_2:
            begin
                ram_wr_data = {p1_px_reg, ram_rd_data[1:0]};
                new_col     = {ram_rd_data[0], ram_rd_data[1], p1_px_reg};
            end
            default:
            begin
                ram_wr_data = ram_rd_data;
                new_col     = ram_rd_data;
            end
        endcase
    end

    // stage 2: window of three columns, newest in cell 2
    cell_ctrl_t cell_ctrl;
    logic [2:0] col_link [4];
    logic [2:0] red3, red2;

    assign cell_ctrl.shift   = p1_take;
    assign cell_ctrl.op      = op_reg;
    assign cell_ctrl.use_top = p2_meta_reg.row_ge2;
    assign col_link[3]       = new_col;

    for (genvar i = 0; i < 3; i++)
    begin : g_cell
        bm3_cell u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl),
            .col_in  (col_link[i + 1]),
            .col_out (col_link[i]),
            .red3    (red3[i]),
            .red2    (red2[i])
        );
    end

    result_t res_a, res_b, res_c, res_d;
    load_t   load;
    logic    left3, left2;

    always_comb
    begin
        left3 = p2_meta_reg.col_ge2 ? red3[0] : op_reg;
        left2 = p2_meta_reg.col_ge2 ? red2[0] : op_reg;

        res_a.pixel     = reduce2(op_reg, reduce2(op_reg, left3, red3[1]), red3[2]);
        res_a.row       = OUT_COORD_W'(p2_meta_reg.row - RW'(1));
        res_a.col       = OUT_COORD_W'(p2_meta_reg.col - CW'(1));
        res_a.frame_end = 1'b0;

        res_b.pixel     = reduce2(op_reg, red3[1], red3[2]);
        res_b.row       = OUT_COORD_W'(p2_meta_reg.row - RW'(1));
        res_b.col       = OUT_COORD_W'(p2_meta_reg.col);
        res_b.frame_end = 1'b0;

        res_c.pixel     = reduce2(op_reg, reduce2(op_reg, left2, red2[1]), red2[2]);
        res_c.row       = OUT_COORD_W'(p2_meta_reg.row);
        res_c.col       = OUT_COORD_W'(p2_meta_reg.col - CW'(1));
        res_c.frame_end = 1'b0;

        res_d.pixel     = reduce2(op_reg, red2[1], red2[2]);
        res_d.row       = OUT_COORD_W'(p2_meta_reg.row);
        res_d.col       = OUT_COORD_W'(p2_meta_reg.col);
        res_d.frame_end = 1'b1;

        load.res[0] = res_a;
        load.res[1] = p2_meta_reg.b_v ? res_b : res_c;
        load.res[2] = res_c;
        load.res[3] = res_d;
        load.count  = CNT_W'($countones({p2_meta_reg.a_v, p2_meta_reg.b_v,
                                         p2_meta_reg.c_v, p2_meta_reg.d_v}));
    end

    result_t out_item;

    bm3_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_en),
        .load       (load),
        .load_ready (load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_item.col, out_item.row, out_item.pixel};
    assign m_axis_tlast = out_item.frame_end;

    `BM3_ASSERT(a_ram_no_collision, (p1_take && in_accept) |-> (p1_meta_reg.col != c_cur), "line store read and write hit the same column")
    `BM3_ASSERT_NEXT(a_p1_fill, in_accept, p1_valid_reg, "transfer did not enter stage 1")
    `BM3_ASSERT_NEXT(a_p2_hold, p2_valid_reg && !load_en, p2_valid_reg, "stage 2 item dropped")

endmodule

// ===== sv/bm3_ram.sv =====
module bm3_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bm3_cell.sv =====
// One window column: bit 0 current row, bit 1 row above, bit 2 two rows above.
module bm3_cell (
    input  logic                clk,
    input  bm3_pkg::cell_ctrl_t ctrl,
    input  logic [2:0]          col_in,
    output logic [2:0]          col_out,
    output logic                red3,
    output logic                red2
);
    import bm3_pkg::*;

    logic [2:0] col_reg;
    logic       top_bit;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    always_comb
    begin
        top_bit = ctrl.use_top ? col_reg[2] : ctrl.op;
        red2    = reduce2(ctrl.op, col_reg[0], col_reg[1]);
        red3    = reduce2(ctrl.op, red2, top_bit);
    end

    assign col_out = col_reg;

endmodule

// ===== sv/bm3_outq.sv =====
module bm3_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_en,
    input  bm3_pkg::load_t   load,
    output logic             load_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output bm3_pkg::result_t out_item
);
    import bm3_pkg::*;

    result_t          slot_reg [NUM_RES];
    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;
    logic             take;

    assign out_valid  = (pend_reg != '0);
    assign take       = out_valid & out_ready;
    assign load_ready = (pend_reg == '0) || ((pend_reg == CNT_W'(1)) && out_ready);
    assign out_item   = slot_reg[0];

    always_comb
    begin
        pend_next = pend_reg;
        if (load_en)
        begin
            pend_next = load.count;
        end
        else if (take)
        begin
            pend_next = pend_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            for (int i = 0; i < NUM_RES; i++)
            begin
                slot_reg[i] <= load.res[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < NUM_RES - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import bm3_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 100;
    localparam int PAD_LO        = 1 + 2 * OUT_COORD_W;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    cfg_index_t             cfg_index     = REG_WIDTH;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // model of the block's registers, raster position and line store
    logic [CFG_W-1:0] img_w    = 11'd1024;
    logic [CFG_W-1:0] img_h    = 11'd1024;
    logic             morph_op = OP_DILATE;
    int               pos_row;
    int               pos_col;
    int               cur_slot;
    int               slot_len [3];
    logic [2:0]       row_bits [MAX_DIM];
    result_t          pending_pixels [$];

    int fail_count;
    int pixels_sent;
    int cycle_count;
    bit no_idle;
    bit hold_request;

    always #4 clk = ~clk;

    binary_morphology_3x3_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic int clamp_dim(int unsigned v);
        if (v < 2)
        begin
            return 2;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return v;
    endfunction

    // 3x3 OR/AND over the neighbors inside the image; cur is the row being received
    function automatic logic filter_window(int rr, int cc, int cur, int w, int h);
        logic acc;
        int   dr;
        int   dc;
        int   x;
        int   y;
        int   back;
        int   b;
        acc = (morph_op == OP_ERODE);
        for (dr = -1; dr <= 1; dr++)
        begin
            x = rr + dr;
            if (x < 0 || x >= h || x > cur)
            begin
                continue;
            end
            back = cur - x;
            if (back > 2)
            begin
                continue;
            end
            b = (cur_slot + 3 - back) % 3;
            for (dc = -1; dc <= 1; dc++)
            begin
                y = cc + dc;
                if (y < 0 || y >= w)
                begin
                    continue;
                end
                if (morph_op == OP_ERODE)
                begin
                    acc = acc & row_bits[y][b];
                end
                else
                begin
                    acc = acc | row_bits[y][b];
                end
            end
        end
        return acc;
    endfunction

    function automatic void queue_pixel(int rr, int cc, int cur, int w, int h);
        result_t res;
        res.pixel     = filter_window(rr, cc, cur, w, h);
        res.row       = OUT_COORD_W'(rr);
        res.col       = OUT_COORD_W'(cc);
        res.frame_end = (rr == h - 1) && (cc == w - 1);
        pending_pixels = {pending_pixels, res};
    endfunction

    function automatic void advance_raster(logic px);
        int w;
        int h;
        int r;
        int c;
        w = clamp_dim(32'(img_w));
        h = clamp_dim(32'(img_h));
        if (pos_col >= w || pos_row >= h)
        begin
            pos_col  = 0;
            pos_row  = 0;
            cur_slot = 0;
        end
        r = pos_row;
        c = pos_col;
        row_bits[c][cur_slot] = px;
        if (slot_len[cur_slot] < c + 1)
        begin
            slot_len[cur_slot] = c + 1;
        end
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                queue_pixel(r - 1, c - 1, r, w, h);
            end
            if (c == w - 1)
            begin
                queue_pixel(r - 1, w - 1, r, w, h);
            end
        end
        if (r == h - 1)
        begin
            if (c >= 1)
            begin
                queue_pixel(r, c - 1, r, w, h);
            end
            if (c == w - 1)
            begin
                queue_pixel(r, w - 1, r, w, h);
            end
        end
        pos_col = c + 1;
        if (pos_col >= w)
        begin
            pos_col  = 0;
            pos_row  = r + 1;
            cur_slot = (cur_slot + 1) % 3;
            if (pos_row >= h)
            begin
                pos_row  = 0;
                cur_slot = 0;
            end
        end
    endfunction

    // widening mid-frame must not reach line store columns never written since reset
    function automatic bit widening_is_safe(int unsigned w_raw, int unsigned h_raw);
        int nw;
        int nh;
        int known;
        nw    = clamp_dim(w_raw);
        nh    = clamp_dim(h_raw);
        known = slot_len[0];
        if (slot_len[1] < known)
        begin
            known = slot_len[1];
        end
        if (slot_len[2] < known)
        begin
            known = slot_len[2];
        end
        return !(pos_row >= 1 && pos_col < nw && pos_row < nh && nw > known);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $error("result row %0d col %0d with nothing expected",
                           m_axis_tdata[10:1], m_axis_tdata[20:11]);
                end
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_out", 32'(want.pixel), 32'(m_axis_tdata[0]));
                check_field("out_row", 32'(want.row), 32'(m_axis_tdata[OUT_COORD_W:1]));
                check_field("out_col", 32'(want.col),
                            32'(m_axis_tdata[PAD_LO-1:OUT_COORD_W+1]));
                check_field("frame_end", 32'(want.frame_end), 32'(m_axis_tlast));
                check_field("tdata_pad", 32'd0, 32'(m_axis_tdata[OUT_TDATA_W-1:PAD_LO]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side: random stalls, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 6);
            end
        end
    end

    task automatic send_pixel(logic px);
        while (!no_idle && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(px);
        do @(posedge clk); while (!s_axis_tready);
        advance_raster(px);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_pixels(int count, int unsigned density);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_pixel($urandom_range(99) < density);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  img_w = val;
            REG_HEIGHT: img_h = val;
            REG_OP:     morph_op = val[0];
            default:    ;
        endcase
        @(negedge clk);
    endtask

    task automatic finish_frame();
        while (pos_row != 0 || pos_col != 0)
        begin
            send_pixel(1'($urandom_range(1)));
        end
    endtask

    // row 0 of a full-width frame: nothing comes out
    task automatic test_reset_defaults();
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
    endtask

    // sizes below 2 act as 2; the old position lies outside, so the frame restarts
    task automatic test_clamped_sizes();
        write_reg(REG_WIDTH, 11'd0);
        write_reg(REG_HEIGHT, 11'd1);
        write_reg(REG_OP, CFG_W'(OP_DILATE));
        send_pixel(1'b0);
        send_pixel(1'b0);
        send_pixel(1'b0);
        send_pixel(1'b0);
        write_reg(REG_OP, CFG_W'(OP_ERODE));
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
    endtask

    task automatic test_midframe_resize();
        write_reg(REG_WIDTH, 11'd3);
        write_reg(REG_HEIGHT, 11'd3);
        write_reg(REG_OP, CFG_W'(OP_DILATE));
        send_pixel(1'b0);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        // row 1 still inside: it becomes the last row
        write_reg(REG_HEIGHT, 11'd2);
        send_pixel(1'b0);
        send_pixel(1'b0);
        write_reg(REG_HEIGHT, 11'd3);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b0);
        send_pixel(1'b0);
        send_pixel(1'b1);
        // column 2 now outside: restart at pixel 0,0
        write_reg(REG_WIDTH, 11'd2);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b0);
    endtask

    task automatic test_output_backpressure();
        finish_frame();
        write_reg(REG_WIDTH, 11'd6);
        write_reg(REG_HEIGHT, 11'd5);
        write_reg(REG_OP, CFG_W'(OP_ERODE));
        hold_request = 1'b1;
        send_pixels(30, 80);
    endtask

    task automatic test_random_frames();
        int unsigned w_raw;
        int unsigned h_raw;
        int          count;
        int          target;
        int          frames;
        target = pixels_sent + 40;
        frames = 0;
        while (pixels_sent < target)
        begin
            w_raw = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(2, 10);
            h_raw = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(2, 6);
            if (!widening_is_safe(w_raw, h_raw))
            begin
                w_raw = 32'(img_w);
            end
            write_reg(REG_WIDTH, CFG_W'(w_raw));
            write_reg(REG_HEIGHT, CFG_W'(h_raw));
            write_reg(REG_OP, CFG_W'($urandom_range(1)));
            count = clamp_dim(w_raw) * clamp_dim(h_raw);
            // some frames are cut short and picked up by the next size
            if ($urandom_range(3) == 0)
            begin
                count = $urandom_range(1, count - 1);
            end
            no_idle = (frames == 2);
            send_pixels(count, $urandom_range(100));
            frames++;
        end
        no_idle = 1'b0;
    endtask

    // sizes above the maximum act as the maximum
    task automatic test_size_limits();
        finish_frame();
        write_reg(REG_WIDTH, 11'd2047);
        write_reg(REG_HEIGHT, 11'd1);
        write_reg(REG_OP, CFG_W'(OP_ERODE));
        send_pixels(16, 95);
        write_reg(REG_WIDTH, 11'd2);
        write_reg(REG_HEIGHT, 11'd2047);
        write_reg(REG_OP, CFG_W'(OP_DILATE));
        no_idle = 1'b1;
        send_pixels(30, 20);
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_clamped_sizes();
        test_midframe_resize();
        test_output_backpressure();
        test_random_frames();
        test_size_limits();
        wait_idle();
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bm3_pkg.sv
sv/bm3_ram.sv
sv/bm3_cell.sv
sv/bm3_outq.sv
sv/binary_morphology_3x3_top.sv
dv/tb_top.sv
